### rtl/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// shared constants for the rational arithmetic and reduction block
// ----------------------------------------------------------------------------
package rar_pkg;

	// default operand width of the input fractions
	localparam int OPERAND_WIDTH_DEF = 16;

	// width of the reduced result parts
	localparam int RES_WIDTH = 33;

	// result word: res_num, res_den, padded to whole bytes
	localparam int OUT_DATA_W = ((2 * RES_WIDTH + 7) / 8) * 8;
	localparam int OUT_PAD    = OUT_DATA_W - 2 * RES_WIDTH;

	// operation codes, unused codes fall back to reduce
	localparam logic [2:0] MODE_REDUCE = 3'd0;
	localparam logic [2:0] MODE_ADD    = 3'd1;
	localparam logic [2:0] MODE_SUB    = 3'd2;
	localparam logic [2:0] MODE_MUL    = 3'd3;
	localparam logic [2:0] MODE_DIV    = 3'd4;

endpackage

### rtl/rar_div.sv
// ----------------------------------------------------------------------------
// rar_div
// iterative signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module rar_div #(
	parameter int WIDTH = 33
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [WIDTH-1:0] dividend,
	input  logic signed [WIDTH-1:0] divisor,
	output logic                    done,
	output logic signed [WIDTH-1:0] quotient,
	output logic signed [WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dsr_q;
	logic             qneg_q;
	logic             rneg_q;

	logic [WIDTH-1:0] dvd_u;
	logic [WIDTH-1:0] dsr_u;
	logic [WIDTH-1:0] dvd_mag;
	logic [WIDTH-1:0] dsr_mag;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;

	assign dvd_u   = dividend;
	assign dsr_u   = divisor;
	assign dvd_mag = dvd_u[WIDTH-1] ? ~dvd_u + 1'b1 : dvd_u;
	assign dsr_mag = dsr_u[WIDTH-1] ? ~dsr_u + 1'b1 : dsr_u;

	// restoring step: bring in the next dividend bit, try the subtract
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse after the last quotient bit
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dvd_mag;
			dsr_q  <= dsr_mag;
			qneg_q <= dvd_u[WIDTH-1] ^ dsr_u[WIDTH-1];
			rneg_q <= dvd_u[WIDTH-1];
		end else if (busy_q) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	// quotient sign from both operands, remainder sign from the dividend
	assign done      = done_q;
	assign quotient  = $signed(qneg_q ? ~quo_q + 1'b1 : quo_q);
	assign remainder = $signed(rneg_q ? ~rem_q + 1'b1 : rem_q);

endmodule

### rtl/rational_arithmetic_reduce.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce
// fraction add, subtract, multiply, divide or reduce, with euclid gcd reduction
// ----------------------------------------------------------------------------
// usage:
//   input words arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries
//   the operation code, s_tdata the two fractions. one result word leaves on
//   m_tvalid/m_tready/m_tdata/m_tuser for every input word; m_tuser flags a
//   raw result of 0/0, which is reported as 0/0.
// timing:
//   one word is worked on at a time; s_tready is high only while idle.
//   the raw fraction is built with one shared multiplier in ST_MUL_DEN,
//   ST_MUL_NUM and ST_MUL_X (then ST_ADD), then every euclid remainder and
//   the two final divisions go through one shared bit-serial divider of
//   2*OPERAND_WIDTH+1 bits. reduce copies the first fraction in ST_MUL_DEN
//   and skips the other products; multiply or divide skip ST_MUL_X and ST_ADD.
//   s_tready rises with m_tvalid. the number k of euclid steps is at most
//   about 1.5 * (2*OPERAND_WIDTH + 1).
// reset and stall:
//   arst_n returns the sequencer to idle and drops m_tvalid. a finished
//   result sits in the output register until taken; while it waits the block
//   still accepts and computes the next word, and holds its own result
//   until the output register frees up.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce
	import rar_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	// input stream
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// num_a, den_a, num_b, den_b
	input  logic [((4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// mode
	input  logic [2:0]                                    s_tuser,
	// output stream
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// res_num, res_den, zero padding
	output logic [OUT_DATA_W-1:0]                         m_tdata,
	// zero_error
	output logic                                          m_tuser
);

	// raw results are exact at this width
	localparam int W  = OPERAND_WIDTH;
	localparam int RW = 2 * OPERAND_WIDTH + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_DEN,
		ST_MUL_NUM,
		ST_MUL_X,
		ST_ADD,
		ST_GCD_INIT,
		ST_GCD_STEP,
		ST_GCD_WAIT,
		ST_QUO_NUM,
		ST_QUO_NUM_WAIT,
		ST_QUO_DEN,
		ST_QUO_DEN_WAIT,
		ST_OUT
	} state_t;

	state_t state_q;

	// captured operands
	logic [2:0]            mode_q;
	logic signed [W-1:0]   na_q;
	logic signed [W-1:0]   da_q;
	logic signed [W-1:0]   nb_q;
	logic signed [W-1:0]   db_q;

	// raw fraction, later overwritten by the reduced fraction
	logic signed [RW-1:0]  rn_q;
	logic signed [RW-1:0]  rd_q;
	logic signed [RW-1:0]  prod_q;

	// euclid working pair
	logic signed [RW-1:0]  n_q;
	logic signed [RW-1:0]  d_q;

	// output register payload
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tvalid_q;

	logic                  in_fire;
	logic                  out_free;
	logic                  is_reduce;
	logic                  is_addsub;

	logic signed [W-1:0]   mul_a;
	logic signed [W-1:0]   mul_b;
	logic signed [2*W-1:0] mul_p;

	logic                  div_start;
	logic signed [RW-1:0]  div_dvd;
	logic signed [RW-1:0]  div_dsr;
	logic                  div_done;
	logic signed [RW-1:0]  div_quo;
	logic signed [RW-1:0]  div_rem;

	logic signed [RES_WIDTH-1:0] res_num;
	logic signed [RES_WIDTH-1:0] res_den;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign is_addsub = (mode_q == MODE_ADD) || (mode_q == MODE_SUB);
	assign is_reduce = !is_addsub && (mode_q != MODE_MUL) && (mode_q != MODE_DIV);

	// shared multiplier, operands picked by the sequencer
	always_comb begin
		mul_a = da_q;
		mul_b = db_q;
		case (state_q)
			ST_MUL_DEN: begin
				mul_a = da_q;
				mul_b = (mode_q == MODE_DIV) ? nb_q : db_q;
			end
			ST_MUL_NUM: begin
				mul_a = na_q;
				mul_b = (mode_q == MODE_MUL) ? nb_q : db_q;
			end
			ST_MUL_X: begin
				mul_a = nb_q;
				mul_b = da_q;
			end
			default: begin
				mul_a = da_q;
				mul_b = db_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// shared divider: euclid remainders, then the two reducing divisions
	always_comb begin
		div_start = 1'b0;
		div_dvd   = d_q;
		div_dsr   = n_q;
		case (state_q)
			ST_GCD_STEP: begin
				div_start = (n_q != '0);
				div_dvd   = d_q;
				div_dsr   = n_q;
			end
			ST_QUO_NUM: begin
				div_start = 1'b1;
				div_dvd   = rn_q;
				div_dsr   = d_q;
			end
			ST_QUO_DEN: begin
				div_start = 1'b1;
				div_dvd   = rd_q;
				div_dsr   = d_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	rar_div #(
		.WIDTH (RW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// results wrap or sign extend to the output width
	assign res_num = RES_WIDTH'(rn_q);
	assign res_den = RES_WIDTH'(rd_q);

	// sequencer and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// load a new result or drop the one just taken
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_MUL_DEN;
					end
				end
				ST_MUL_DEN: begin
					state_q <= is_reduce ? ST_GCD_INIT : ST_MUL_NUM;
				end
				ST_MUL_NUM: begin
					state_q <= is_addsub ? ST_MUL_X : ST_GCD_INIT;
				end
				ST_MUL_X: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_GCD_INIT;
				end
				ST_GCD_INIT: begin
					state_q <= ST_GCD_STEP;
				end
				ST_GCD_STEP: begin
					if (n_q != '0) begin
						state_q <= ST_GCD_WAIT;
					end else if (d_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_QUO_NUM;
					end
				end
				ST_GCD_WAIT: begin
					if (div_done) begin
						state_q <= ST_GCD_STEP;
					end
				end
				ST_QUO_NUM: begin
					state_q <= ST_QUO_NUM_WAIT;
				end
				ST_QUO_NUM_WAIT: begin
					if (div_done) begin
						state_q <= ST_QUO_DEN;
					end
				end
				ST_QUO_DEN: begin
					state_q <= ST_QUO_DEN_WAIT;
				end
				ST_QUO_DEN_WAIT: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					mode_q <= s_tuser;
					na_q   <= $signed(s_tdata[W-1:0]);
					da_q   <= $signed(s_tdata[2*W-1:W]);
					nb_q   <= $signed(s_tdata[3*W-1:2*W]);
					db_q   <= $signed(s_tdata[4*W-1:3*W]);
				end
			end
			ST_MUL_DEN: begin
				if (is_reduce) begin
					rn_q <= RW'(na_q);
					rd_q <= RW'(da_q);
				end else begin
					rd_q <= RW'(mul_p);
				end
			end
			ST_MUL_NUM: begin
				rn_q <= RW'(mul_p);
			end
			ST_MUL_X: begin
				prod_q <= RW'(mul_p);
			end
			ST_ADD: begin
				rn_q <= (mode_q == MODE_SUB) ? rn_q - prod_q : rn_q + prod_q;
			end
			ST_GCD_INIT: begin
				n_q <= rn_q;
				d_q <= rd_q;
			end
			ST_GCD_WAIT: begin
				// d, n <- n, d rem n
				if (div_done) begin
					d_q <= n_q;
					n_q <= div_rem;
				end
			end
			ST_QUO_NUM_WAIT: begin
				if (div_done) begin
					rn_q <= div_quo;
				end
			end
			ST_QUO_DEN_WAIT: begin
				if (div_done) begin
					rd_q <= div_quo;
				end
			end
			ST_OUT: begin
				// a zero gcd only comes from a 0/0 raw fraction, which already reads 0/0
				if (out_free) begin
					m_tdata_q <= {{OUT_PAD{1'b0}}, res_den, res_num};
					m_tuser_q <= (d_q == '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
